FILE: design/kwsc_pkg.sv
// ----------------------------------------------------------------------------
// Keyword substitution cipher: shared package
// Letter decode, codes, widths and the table access request type.
// ----------------------------------------------------------------------------
package kwsc_pkg;

    localparam int LETTERS = 26;
    localparam int IDX_W   = $clog2(LETTERS);
    localparam int CNT_W   = $clog2(LETTERS + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Item kinds
    localparam logic [1:0] KIND_KEY = 2'd0;
    localparam logic [1:0] KIND_MSG = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;

    localparam logic [6:0] ASCII_A     = 7'h41;
    localparam logic [6:0] ASCII_SPACE = 7'h20;
    localparam logic [3:0] DEFAULT_GROUP = 4'd4;

    // Decoded letter: hit is set for A..Z or a..z
    typedef struct packed {
        logic hit;
        idx_t idx;
    } letter_t;

    // Cipher table request from the sequencer
    typedef struct packed {
        logic wr_en;
        idx_t wr_addr;
        idx_t wr_data;
        logic rd_en;
        idx_t rd_addr;
    } tbl_req_t;

    function automatic letter_t letter_decode(input logic [7:0] c);
        letter_t r;
        r.hit = 1'b0;
        r.idx = '0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r.hit = 1'b1;
            r.idx = IDX_W'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            r.hit = 1'b1;
            r.idx = IDX_W'(c - 8'h61);
        end
        return r;
    endfunction

endpackage

FILE: design/kwsc_table.sv
// ----------------------------------------------------------------------------
// Cipher table memory
// 26-entry alphabet store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kwsc_table
    import kwsc_pkg::*;
(
    input  logic     clk,
    input  tbl_req_t req,
    output idx_t     rd_data
);

    idx_t mem [LETTERS];
    idx_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/kwsc_ctrl.sv
// ----------------------------------------------------------------------------
// Cipher sequencer
// Keyword append, alphabet fill sweep, lookup and grouped output.
// ----------------------------------------------------------------------------
module kwsc_ctrl
    import kwsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [3:0] group_len,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] char_out,
    output logic       run_last,
    output tbl_req_t   tbl_req,
    input  idx_t       tbl_rd_data
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_FILL    = 3'd1;
    localparam logic [2:0] S_LOOKUP  = 3'd2;
    localparam logic [2:0] S_CAPTURE = 3'd3;
    localparam logic [2:0] S_SPACE   = 3'd4;
    localparam logic [2:0] S_LETTER  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [LETTERS-1:0] seen_reg, seen_next;
    cnt_t               count_reg, count_next;
    logic               complete_reg, complete_next;
    logic [3:0]         gpos_reg, gpos_next;
    logic               emitted_reg, emitted_next;
    idx_t               fill_reg, fill_next;
    logic               hit_reg, hit_next;
    logic               out_valid_reg, out_valid_next;
    idx_t               idx_reg, idx_next;
    logic [6:0]         letter_reg, letter_next;
    logic [6:0]         char_out_reg, char_out_next;
    logic               run_last_reg, run_last_next;

    letter_t            dec;
    logic               has_room;

    assign dec      = letter_decode(char_in);
    assign has_room = (count_reg < CNT_W'(LETTERS));

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        seen_next      = seen_reg;
        count_next     = count_reg;
        complete_next  = complete_reg;
        gpos_next      = gpos_reg;
        emitted_next   = emitted_reg;
        fill_next      = fill_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        letter_next    = letter_reg;
        char_out_next  = char_out_reg;
        run_last_next  = run_last_reg;
        tbl_req        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (kind)
                        KIND_KEY:
                        begin
                            // append a new keyword letter
                            if (!complete_reg && dec.hit && has_room && !seen_reg[dec.idx])
                            begin
                                tbl_req.wr_en   = 1'b1;
                                tbl_req.wr_addr = IDX_W'(count_reg);
                                tbl_req.wr_data = dec.idx;
                                count_next      = count_reg + 1'b1;
                                seen_next       = seen_reg | (LETTERS'(1) << dec.idx);
                            end
                        end
                        KIND_MSG:
                        begin
                            idx_next = dec.idx;
                            hit_next = dec.hit;
                            if (!complete_reg)
                            begin
                                fill_next  = '0;
                                state_next = S_FILL;
                            end
                            else
                            begin
                                state_next = S_LOOKUP;
                            end
                        end
                        KIND_END:
                        begin
                            seen_next     = '0;
                            count_next    = '0;
                            complete_next = 1'b0;
                            gpos_next     = '0;
                            emitted_next  = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                // one candidate letter per cycle
                if (has_room && !seen_reg[fill_reg])
                begin
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_addr = IDX_W'(count_reg);
                    tbl_req.wr_data = fill_reg;
                    count_next      = count_reg + 1'b1;
                    seen_next       = seen_reg | (LETTERS'(1) << fill_reg);
                end
                if (fill_reg == IDX_W'(LETTERS - 1))
                begin
                    complete_next = 1'b1;
                    state_next    = S_LOOKUP;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            S_LOOKUP:
            begin
                if (hit_reg)
                begin
                    tbl_req.rd_en   = 1'b1;
                    tbl_req.rd_addr = idx_reg;
                    state_next      = S_CAPTURE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CAPTURE:
            begin
                letter_next    = ASCII_A + 7'(tbl_rd_data);
                out_valid_next = 1'b1;
                emitted_next   = 1'b1;
                // space opens every group after the first
                if (emitted_reg && gpos_reg >= group_len)
                begin
                    char_out_next = ASCII_SPACE;
                    run_last_next = 1'b0;
                    gpos_next     = 4'd1;
                    state_next    = S_SPACE;
                end
                else
                begin
                    char_out_next = ASCII_A + 7'(tbl_rd_data);
                    run_last_next = 1'b1;
                    gpos_next     = gpos_reg + 1'b1;
                    state_next    = S_LETTER;
                end
            end
            S_SPACE:
            begin
                if (!out_stall)
                begin
                    char_out_next = letter_reg;
                    run_last_next = 1'b1;
                    state_next    = S_LETTER;
                end
            end
            S_LETTER:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seen_reg      <= '0;
            count_reg     <= '0;
            complete_reg  <= 1'b0;
            gpos_reg      <= '0;
            emitted_reg   <= 1'b0;
            fill_reg      <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            count_reg     <= count_next;
            complete_reg  <= complete_next;
            gpos_reg      <= gpos_next;
            emitted_reg   <= emitted_next;
            fill_reg      <= fill_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        letter_reg   <= letter_next;
        char_out_reg <= char_out_next;
        run_last_reg <= run_last_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign char_out  = char_out_reg;
    assign run_last  = run_last_reg;

endmodule

FILE: design/keyword_substitution_cipher_unit.sv
// ----------------------------------------------------------------------------
// Keyword substitution cipher unit
// Builds a cipher alphabet from keyword letters and encodes message letters
// into space-separated groups.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_stall stays high until all its output is
// delivered. Keyword characters and end-of-message requests finish in the
// accept cycle. A message letter passes through accept, registered table read
// and capture, then presents each output character in turn; a dropped
// non-letter message character passes through accept and lookup only. The
// first message character after reset or end of message adds a sweep that
// fills the unused letters into the table one candidate per cycle.
// Output backpressure holds each output character until it is taken. group_length is written over
// the cfg channel, which is always ready; reset value is 4.
module keyword_substitution_cipher_unit
    import kwsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] group_length,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] char_out,
    output logic       run_last
);

    logic [3:0] group_length_reg;
    tbl_req_t   tbl_req;
    idx_t       tbl_rd_data;

    // Group length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_length_reg <= DEFAULT_GROUP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            group_length_reg <= group_length;
        end
    end

    assign cfg_ready = 1'b1;

    kwsc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .group_len   (group_length_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .char_in     (char_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_out    (char_out),
        .run_last    (run_last),
        .tbl_req     (tbl_req),
        .tbl_rd_data (tbl_rd_data)
    );

    kwsc_table u_table (
        .clk     (clk),
        .req     (tbl_req),
        .rd_data (tbl_rd_data)
    );

endmodule

FILE: dv/keyword_substitution_cipher_unit_test.sv
// ----------------------------------------------------------------------------
// Keyword substitution cipher unit: self-checking testbench
// A short table of hand-picked requests is run first. Then random keywords
// and messages are run under several group lengths. Output of typed directed
// rows is checked against the row's listed chars, the rest against an in-bench cipher predictor.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher_unit_test;
    import kwsc_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 40;     // sweep + lookup + margin
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES = 7;
    localparam int ITEMS_PER_PHASE = 200;

    // One output character and its end-of-request flag
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } cipher_char_t;

    // Directed request; typed rows carry their expected output
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       typed;
        logic [1:0] n;
        logic [7:0] c0;
        logic [7:0] c1;
    } stim_row_t;

    localparam stim_row_t DIRECTED [25] = '{
        // empty keyword: identity alphabet
        '{KIND_MSG,    "a",   1'b1, 2'd1, "A", 8'h00},
        '{KIND_MSG,    "Z",   1'b1, 2'd1, "Z", 8'h00},
        '{KIND_MSG,    8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
        '{KIND_MSG,    8'hFF, 1'b1, 2'd0, 8'h00, 8'h00},
        '{KIND_MSG,    "m",   1'b1, 2'd1, "M", 8'h00},
        '{KIND_MSG,    "B",   1'b1, 2'd1, "B", 8'h00},
        // fifth letter opens a new group of four
        '{KIND_MSG,    "c",   1'b1, 2'd2, " ", "C"},
        '{KIND_END,    8'h41, 1'b1, 2'd0, 8'h00, 8'h00},
        // keyword "ZE" with a repeat, non-letters and an unused kind
        '{KIND_KEY,    "Z",   1'b1, 2'd0, 8'h00, 8'h00},
        '{KIND_KEY,    "z",   1'b1, 2'd0, 8'h00, 8'h00},
        '{KIND_KEY,    "1",   1'b1, 2'd0, 8'h00, 8'h00},
        '{KIND_KEY,    8'hE1, 1'b1, 2'd0, 8'h00, 8'h00},
        '{KIND_KEY,    "e",   1'b1, 2'd0, 8'h00, 8'h00},
        '{KIND_UNUSED, "Q",   1'b1, 2'd0, 8'h00, 8'h00},
        '{KIND_MSG,    "A",   1'b1, 2'd1, "Z", 8'h00},
        // keyword after message start is ignored
        '{KIND_KEY,    "Q",   1'b1, 2'd0, 8'h00, 8'h00},
        '{KIND_MSG,    "b",   1'b1, 2'd1, "E", 8'h00},
        '{KIND_MSG,    "C",   1'b1, 2'd1, "A", 8'h00},
        '{KIND_MSG,    "q",   1'b0, 2'd0, 8'h00, 8'h00},
        '{KIND_MSG,    "z",   1'b0, 2'd0, 8'h00, 8'h00},
        // bytes just outside the letter ranges
        '{KIND_MSG,    "@",   1'b1, 2'd0, 8'h00, 8'h00},
        '{KIND_MSG,    "[",   1'b1, 2'd0, 8'h00, 8'h00},
        '{KIND_MSG,    8'h60, 1'b1, 2'd0, 8'h00, 8'h00},
        '{KIND_MSG,    "{",   1'b1, 2'd0, 8'h00, 8'h00},
        '{KIND_END,    8'hFF, 1'b1, 2'd0, 8'h00, 8'h00}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] group_length;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] kind;
    logic [7:0] char_in;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [6:0] char_out;
    logic       run_last;

    logic steady = 1'b0;          // no idling on either side while set
    int   mismatches = 0;
    int   requests_sent = 0;
    int   idle_cycles = 0;
    cipher_char_t expected_chars [$];
    cipher_char_t head_char;

    // Predictor state
    idx_t                 code_table [LETTERS];
    logic [LETTERS-1:0]   letters_used;
    cnt_t                 key_fill;
    logic                 alphabet_done;
    logic [3:0]           group_pos;
    logic                 any_letter;
    logic [3:0]           group_len;

    keyword_substitution_cipher_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .group_length (group_length),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .char_in      (char_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .char_out     (char_out),
        .run_last     (run_last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver backpressure
    always @(posedge clk)
    begin
        out_stall <= steady ? 1'b0 : ($urandom_range(99) < 26);
    end

    // ------------------------------------------------------------------
    // Cipher predictor
    // ------------------------------------------------------------------

    // Letter index of a byte, case folded; returns 0 for a non-letter
    function automatic logic letter_of(input logic [7:0] c, output idx_t i);
        i = '0;
        if (c >= "a" && c <= "z")
        begin
            i = idx_t'(c - "a");
            return 1'b1;
        end
        if (c >= "A" && c <= "Z")
        begin
            i = idx_t'(c - "A");
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void add_to_alphabet(input idx_t i);
        if (key_fill < cnt_t'(LETTERS) && !letters_used[i])
        begin
            code_table[key_fill] = i;
            key_fill = key_fill + 1'b1;
            letters_used[i] = 1'b1;
        end
    endfunction

    function automatic void clear_message();
        letters_used  = '0;
        key_fill      = '0;
        alphabet_done = 1'b0;
        group_pos     = '0;
        any_letter    = 1'b0;
    endfunction

    // Advances the predictor by one request; returns the number of chars
    function automatic int encode_step(input logic [1:0] k, input logic [7:0] c,
                                       output cipher_char_t res [2]);
        idx_t i;
        logic hit;
        int   n;
        n = 0;
        res[0] = '0;
        res[1] = '0;
        hit = letter_of(c, i);
        if (k == KIND_END)
            clear_message();
        else if (k == KIND_KEY)
        begin
            if (!alphabet_done && hit)
                add_to_alphabet(i);
        end
        else if (k == KIND_MSG)
        begin
            // first message char fills the unused letters in order
            if (!alphabet_done)
            begin
                for (int l = 0; l < LETTERS; l++)
                    add_to_alphabet(idx_t'(l));
                alphabet_done = 1'b1;
            end
            if (hit)
            begin
                if (any_letter && group_pos >= group_len)
                begin
                    res[0] = '{ch: ASCII_SPACE, last: 1'b0};
                    n = 1;
                    group_pos = '0;
                end
                res[n] = '{ch: ASCII_A + 7'(code_table[i]), last: 1'b1};
                n++;
                group_pos = group_pos + 1'b1;
                any_letter = 1'b1;
            end
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Output checking
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected char: expected none, got char_out %h run_last %b",
                         $time, char_out, run_last);
                mismatches++;
            end
            else
            begin
                head_char = expected_chars.pop_front();
                if (char_out !== head_char.ch)
                begin
                    $display("%0t: char_out expected %h got %h",
                             $time, head_char.ch, char_out);
                    mismatches++;
                end
                if (run_last !== head_char.last)
                begin
                    $display("%0t: run_last expected %b got %b",
                             $time, head_char.last, run_last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: cycles with no request moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, %0d chars still expected",
                         $time, expected_chars.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one request and return at the edge that accepts it
    task automatic offer(input logic [1:0] k, input logic [7:0] c);
        while (!steady && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        char_in  <= c;
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
    endtask

    task automatic send_predicted(input logic [1:0] k, input logic [7:0] c);
        cipher_char_t res [2];
        int n;
        offer(k, c);
        n = encode_step(k, c, res);
        for (int r = 0; r < n; r++)
            expected_chars.push_back(res[r]);
    endtask

    // Sender holds off until every char is out and the block is idle
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_group(input logic [3:0] v);
        cfg_valid    <= 1'b1;
        group_length <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        group_len = v;
    endtask

    function automatic logic [7:0] cased_letter(input int i);
        return ($urandom_range(1) ? "A" : "a") + 8'(i);
    endfunction

    // One keyword and message, mostly well formed with some noise
    task automatic send_message();
        int step;
        int first;
        int len;
        int r;
        if ($urandom_range(99) < 70)
            send_predicted(KIND_END, 8'($urandom_range(255)));
        if ($urandom_range(99) < 12)
        begin
            // keyword holding all 26 letters in a scrambled order
            step = 2 * $urandom_range(12) + 1;
            if (step == 13)
                step = 1;
            first = $urandom_range(25);
            for (int i = 0; i < LETTERS; i++)
                send_predicted(KIND_KEY, cased_letter((first + i * step) % LETTERS));
        end
        else
        begin
            len = $urandom_range(12);
            for (int i = 0; i < len; i++)
            begin
                r = $urandom_range(99);
                if (r < 85)
                    send_predicted(KIND_KEY, cased_letter($urandom_range(25)));
                else if (r < 97)
                    send_predicted(KIND_KEY, 8'($urandom_range(255)));
                else
                    send_predicted(KIND_UNUSED, 8'($urandom_range(255)));
            end
        end
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(99);
            if (r < 82)
                send_predicted(KIND_MSG, cased_letter($urandom_range(25)));
            else if (r < 92)
                send_predicted(KIND_MSG, 8'($urandom_range(255)));
            else if (r < 96)
                send_predicted(KIND_KEY, cased_letter($urandom_range(25)));
            else
                send_predicted(KIND_UNUSED, 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        cipher_char_t res [2];
        int n;
        int phase_end;
        logic [3:0] gl;

        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        group_length = '0;
        in_valid     = 1'b0;
        kind         = KIND_KEY;
        char_in      = '0;
        foreach (code_table[i])
            code_table[i] = '0;
        clear_message();
        group_len = DEFAULT_GROUP;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at the reset group length
        foreach (DIRECTED[r])
        begin
            if (DIRECTED[r].typed)
            begin
                offer(DIRECTED[r].kind, DIRECTED[r].ch);
                n = encode_step(DIRECTED[r].kind, DIRECTED[r].ch, res);
                if (DIRECTED[r].n >= 2'd1)
                    expected_chars.push_back('{ch: DIRECTED[r].c0[6:0],
                                               last: DIRECTED[r].n == 2'd1});
                if (DIRECTED[r].n == 2'd2)
                    expected_chars.push_back('{ch: DIRECTED[r].c1[6:0], last: 1'b1});
            end
            else
                send_predicted(DIRECTED[r].kind, DIRECTED[r].ch);
        end
        drain();

        // Random phases; a phase may leave a message open across a new length
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: gl = 4'd1;
                1: gl = 4'd15;
                2: gl = 4'd0;
                default: gl = 4'($urandom_range(2, 14));
            endcase
            write_group(gl);
            steady <= (phase == 3);
            phase_end = requests_sent + ITEMS_PER_PHASE;
            while (requests_sent < phase_end)
                send_message();
            drain();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
